// ===== sv/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the page reference count table
// Request and response transaction structs, action and status codes, and the
// control and flag groups of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int IdxW    = 6;
  localparam int CountW  = 32;
  localparam int BytesW  = 32;
  localparam int PagesW  = 7;
  localparam int DBytesW = 39;

  localparam logic [2:0] ACT_INIT     = 3'd0;
  localparam logic [2:0] ACT_INCREF   = 3'd1;
  localparam logic [2:0] ACT_DECREF   = 3'd2;
  localparam logic [2:0] ACT_QUERY    = 3'd3;
  localparam logic [2:0] ACT_MARKDEAD = 3'd4;
  localparam logic [2:0] ACT_STATS    = 3'd5;
  localparam logic [2:0] ACT_COLLECT  = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOTFOUND  = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_NONZERO   = 3'd3;
  localparam logic [2:0] ST_NONEDEAD  = 3'd4;
  localparam logic [2:0] ST_SAT       = 3'd5;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [2:0]        action;
    logic [IdxW-1:0]   page_index;
    logic [BytesW-1:0] page_bytes;
  } prt_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [CountW-1:0]  count_value;
    logic               is_dead;
    logic [IdxW-1:0]    found_page;
    logic [PagesW-1:0]  pages_total;
    logic [PagesW-1:0]  pages_live;
    logic [PagesW-1:0]  pages_dead;
    logic [DBytesW-1:0] bytes_dead;
    logic               last;
  } prt_rsp_t;

  typedef struct packed {
    logic sub;
  } prt_alu_ctl_t;

  typedef struct packed {
    logic a_zero;
    logic a_max;
    logic res_zero;
  } prt_alu_flags_t;

endpackage

// ===== sv/prt_ram.sv =====
// ----------------------------------------------------------------------------
// prt_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module prt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/prt_alu.sv =====
// ----------------------------------------------------------------------------
// prt_alu: shared add/subtract unit of the page reference count table
// Serves count increment/decrement and the dead byte accumulation.
// ----------------------------------------------------------------------------
module prt_alu (
  input  logic [prt_pkg::DBytesW-1:0] a_i,
  input  logic [prt_pkg::CountW-1:0]  b_i,
  input  prt_pkg::prt_alu_ctl_t       ctl_i,
  output logic [prt_pkg::DBytesW-1:0] res_o,
  output prt_pkg::prt_alu_flags_t     flags_o
);
  import prt_pkg::*;

  logic [DBytesW-1:0] b_ext;

  assign b_ext = {{(DBytesW - CountW){1'b0}}, b_i};
  assign res_o = ctl_i.sub ? (a_i - b_ext) : (a_i + b_ext);

  assign flags_o.a_zero   = (a_i[CountW-1:0] == '0);
  assign flags_o.a_max    = (a_i[CountW-1:0] == COUNT_MAX);
  assign flags_o.res_zero = (res_o[CountW-1:0] == '0);

endmodule

// ===== sv/page_refcount_table.sv =====
// ----------------------------------------------------------------------------
// page_refcount_table: page reference count table with dead marking
// Point requests read or update one entry; scans report stats or list dead pages.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i) carries one request
//   transaction: action, page index and page size. Output channel
//   (out_valid_o / out_stall_i / out_o) carries result transactions; out_o.last
//   marks the final result of a request.
//   Point actions (init, incref, decref, query, mark dead) first read the
//   count RAM, then, once the output is free, update it and load the output
//   register.
//   Stats scan handles each entry as one size RAM read plus one pass through
//   the shared adder, then loads the totals into the output register.
//   Collect scan walks one index per cycle up to the last dead page, holding
//   at a dead page while the output stalls; each dead page gives one result,
//   ascending index. With no dead page it gives one none-dead result.
//   Only one request is in flight: in_stall_o is high from acceptance until
//   the last result is loaded into the output register.
//   Output stall holds the output register and freezes the sequencer when it
//   has a result to load.
//   Reset clears the present and dead flags and the control state; the count
//   and size RAMs are not cleared, entries read only once init has written.
// ----------------------------------------------------------------------------
module page_refcount_table #(
  parameter int PAGES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  prt_pkg::prt_req_t in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prt_pkg::prt_rsp_t out_o
);
  import prt_pkg::*;

  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(PAGES - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POINT  = 3'd1;
  localparam logic [2:0] S_ST_RD  = 3'd2;
  localparam logic [2:0] S_ST_ACC = 3'd3;
  localparam logic [2:0] S_ST_OUT = 3'd4;
  localparam logic [2:0] S_COLL   = 3'd5;

  logic [2:0] state_q, state_d;
  prt_req_t   req_q, req_d;
  logic [AW-1:0] scan_q, scan_d;

  // per-entry flags in flops, cleared at reset
  logic [PAGES-1:0] present_q, present_d;
  logic [PAGES-1:0] dead_q, dead_d;

  // stats accumulators
  logic [PagesW-1:0]  total_q, total_d;
  logic [PagesW-1:0]  live_q, live_d;
  logic [PagesW-1:0]  deadn_q, deadn_d;
  logic [DBytesW-1:0] dbytes_q, dbytes_d;

  // output register
  logic     out_valid_q, out_valid_d;
  prt_rsp_t out_q, out_d;
  logic     out_free;

  // RAMs
  logic              cnt_we;
  logic [AW-1:0]     cnt_raddr;
  logic [CountW-1:0] cnt_wdata;
  logic [CountW-1:0] cnt_rdata;
  logic              size_we;
  logic [BytesW-1:0] size_rdata;

  // shared unit
  logic [DBytesW-1:0] alu_a;
  logic [CountW-1:0]  alu_b;
  prt_alu_ctl_t       alu_ctl;
  logic [DBytesW-1:0] alu_res;
  prt_alu_flags_t     alu_flags;

  logic [AW-1:0]    idx_a;
  logic             in_range;
  logic [PAGES-1:0] pd_vec;
  logic [PAGES-1:0] above_scan;
  logic             last_dead;

  assign idx_a    = req_q.page_index[AW-1:0];
  assign in_range = ({1'b0, req_q.page_index} < 7'(PAGES));
  assign pd_vec   = present_q & dead_q;

  always_comb begin
    for (int k = 0; k < PAGES; k++) begin
      above_scan[k] = (k > int'(scan_q));
    end
  end

  assign last_dead = ~|(pd_vec & above_scan);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // count RAM read address: incoming index while idle, held index afterwards
  assign cnt_raddr = (state_q == S_IDLE) ? in_i.page_index[AW-1:0] : idx_a;

  prt_ram #(
    .WIDTH (CountW),
    .DEPTH (PAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx_a),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  prt_ram #(
    .WIDTH (BytesW),
    .DEPTH (PAGES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (idx_a),
    .wdata_i (req_q.page_bytes),
    .raddr_i (scan_q),
    .rdata_o (size_rdata)
  );

  // shared adder: count +/- 1 on point ops, byte accumulation on stats
  always_comb begin
    if (state_q == S_POINT) begin
      alu_a       = {{(DBytesW - CountW){1'b0}}, cnt_rdata};
      alu_b       = CountW'(1);
      alu_ctl.sub = (req_q.action == ACT_DECREF);
    end else begin
      alu_a       = dbytes_q;
      alu_b       = size_rdata;
      alu_ctl.sub = 1'b0;
    end
  end

  prt_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .ctl_i   (alu_ctl),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    scan_d      = scan_q;
    present_d   = present_q;
    dead_d      = dead_q;
    total_d     = total_q;
    live_d      = live_q;
    deadn_d     = deadn_q;
    dbytes_d    = dbytes_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cnt_we      = 1'b0;
    cnt_wdata   = alu_res[CountW-1:0];
    size_we     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_i;
          scan_d = '0;
          unique case (in_i.action) inside
            ACT_STATS: begin
              total_d  = '0;
              live_d   = '0;
              deadn_d  = '0;
              dbytes_d = '0;
              state_d  = S_ST_RD;
            end
            ACT_COLLECT: state_d = S_COLL;
            ACT_INIT, ACT_INCREF, ACT_DECREF, ACT_QUERY, ACT_MARKDEAD:
              state_d = S_POINT;
            default: state_d = S_IDLE;  // unused code, dropped
          endcase
        end
      end

      S_POINT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
          if (!in_range) begin
            out_d.status = ST_NOTFOUND;
          end else if (req_q.action == ACT_INIT) begin
            present_d[idx_a]  = 1'b1;
            dead_d[idx_a]     = 1'b0;
            cnt_we            = 1'b1;
            cnt_wdata         = CountW'(1);
            size_we           = 1'b1;
            out_d.status      = ST_OK;
            out_d.count_value = CountW'(1);
          end else if (!present_q[idx_a]) begin
            out_d.status = ST_NOTFOUND;
          end else begin
            out_d.status      = ST_OK;
            out_d.count_value = cnt_rdata;
            out_d.is_dead     = dead_q[idx_a];
            unique case (req_q.action)
              ACT_INCREF: begin
                if (alu_flags.a_max) begin
                  out_d.status = ST_SAT;
                end else begin
                  cnt_we            = 1'b1;
                  out_d.count_value = alu_res[CountW-1:0];
                end
              end
              ACT_DECREF: begin
                if (alu_flags.a_zero) begin
                  out_d.status = ST_ZERO;
                end else begin
                  cnt_we            = 1'b1;
                  out_d.count_value = alu_res[CountW-1:0];
                  if (alu_flags.res_zero) begin
                    dead_d[idx_a] = 1'b1;
                    out_d.is_dead = 1'b1;
                  end
                end
              end
              ACT_MARKDEAD: begin
                if (!alu_flags.a_zero) begin
                  out_d.status = ST_NONZERO;
                end else begin
                  dead_d[idx_a] = 1'b1;
                  out_d.is_dead = 1'b1;
                end
              end
              default: ;  // query: read only
            endcase
          end
        end
      end

      S_ST_RD: state_d = S_ST_ACC;  // size RAM read in flight

      S_ST_ACC: begin
        if (present_q[scan_q]) begin
          total_d = total_q + PagesW'(1);
          if (dead_q[scan_q]) begin
            deadn_d  = deadn_q + PagesW'(1);
            dbytes_d = alu_res;
          end else begin
            live_d = live_q + PagesW'(1);
          end
        end
        if (scan_q == LastIdx) begin
          state_d = S_ST_OUT;
        end else begin
          scan_d  = scan_q + AW'(1);
          state_d = S_ST_RD;
        end
      end

      S_ST_OUT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.status      = ST_OK;
          out_d.pages_total = total_q;
          out_d.pages_live  = live_q;
          out_d.pages_dead  = deadn_q;
          out_d.bytes_dead  = dbytes_q;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_COLL: begin
        if (pd_vec == '0) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_d        = '0;
            out_d.status = ST_NONEDEAD;
            out_d.last   = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (pd_vec[scan_q]) begin
          if (out_free) begin
            out_valid_d      = 1'b1;
            out_d            = '0;
            out_d.status     = ST_OK;
            out_d.is_dead    = 1'b1;
            out_d.found_page = IdxW'(scan_q);
            out_d.last       = last_dead;
            if (last_dead) begin
              state_d = S_IDLE;
            end else begin
              scan_d = scan_q + AW'(1);
            end
          end
        end else begin
          // a dead page lies above, so scan_q is below the last index here
          scan_d = scan_q + AW'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      present_q   <= '0;
      dead_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      present_q   <= present_d;
      dead_q      <= dead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    total_q  <= total_d;
    live_q   <= live_d;
    deadn_q  <= deadn_d;
    dbytes_q <= dbytes_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== tb/tb_page_refcount_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_refcount_table: self-checking testbench of the page reference table
// Drives request transactions with random gaps and output stalls, and keeps a
// shadow copy of the table that predicts every result transaction. Results
// are compared field by field, in order, with the predicted ones.
// ----------------------------------------------------------------------------
module tb_page_refcount_table;
  import prt_pkg::*;

  localparam int          PAGES_N    = 64;
  localparam int          QUIET_MAX  = 2000;  // cycles with no transaction at all
  localparam int          RAND_ITEMS = 20;
  localparam int          SHOW_MAX   = 10;
  // only code the block does not decode; it must be dropped silently
  localparam logic [2:0]  ACT_UNUSED = 3'd7;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_stall_i = 1'b0;
  prt_req_t in_i        = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  prt_rsp_t out_o;

  page_refcount_table #(
    .PAGES(PAGES_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow table. Nothing present, all counts and dead flags zero; the block
  // resets only its flags, not counts. Sizes are only read for present pages.
  // --------------------------------------------------------------------------
  bit               pg_present [PAGES_N];
  logic [CountW-1:0] pg_refs   [PAGES_N];
  bit               pg_dead    [PAGES_N];
  logic [BytesW-1:0] pg_bytes  [PAGES_N];

  prt_rsp_t rsp_due[$];        // results owed by the block, oldest first

  int  errors          = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  scans_stats     = 0;
  int  scans_collect   = 0;
  int  longest_run     = 0;    // most results from one collect
  bit  no_idle         = 1'b0; // no input gaps, no new stall bursts while set

  initial begin
    for (int i = 0; i < PAGES_N; i++) begin
      pg_present[i] = 1'b0;
      pg_refs[i]    = '0;
      pg_dead[i]    = 1'b0;
      pg_bytes[i]   = '0;
    end
  end

  // Work out what one accepted request does to the table and queue the
  // results it owes.
  task automatic apply_page_action(input prt_req_t req);
    prt_rsp_t           r;
    int                 idx;
    int                 n_dead;
    int                 k;
    logic [PagesW-1:0]  tot;
    logic [PagesW-1:0]  live;
    logic [PagesW-1:0]  deadn;
    logic [DBytesW-1:0] dbytes;
    idx = int'(req.page_index);
    r = '0;
    r.last = 1'b1;
    case (req.action) inside
      ACT_INIT, ACT_INCREF, ACT_DECREF, ACT_QUERY, ACT_MARKDEAD: begin
        if (idx >= PAGES_N || (req.action != ACT_INIT && !pg_present[idx])) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.status = ST_OK;
          case (req.action)
            ACT_INIT: begin
              pg_present[idx] = 1'b1;
              pg_refs[idx]    = 1;
              pg_dead[idx]    = 1'b0;
              pg_bytes[idx]   = req.page_bytes;
            end
            ACT_INCREF: begin
              if (pg_refs[idx] == COUNT_MAX) r.status = ST_SAT;
              else pg_refs[idx] = pg_refs[idx] + 1;
            end
            ACT_DECREF: begin
              if (pg_refs[idx] == 0) begin
                r.status = ST_ZERO;
              end else begin
                pg_refs[idx] = pg_refs[idx] - 1;
                if (pg_refs[idx] == 0) pg_dead[idx] = 1'b1;
              end
            end
            ACT_MARKDEAD: begin
              if (pg_refs[idx] != 0) r.status = ST_NONZERO;
              else pg_dead[idx] = 1'b1;
            end
            default: ;  // query leaves the entry alone
          endcase
          r.count_value = pg_refs[idx];
          r.is_dead     = pg_dead[idx];
        end
        rsp_due.push_back(r);
      end
      ACT_STATS: begin
        tot = '0;
        live = '0;
        deadn = '0;
        dbytes = '0;
        for (int i = 0; i < PAGES_N; i++) begin
          if (pg_present[i]) begin
            tot++;
            if (pg_dead[i]) begin
              deadn++;
              dbytes = dbytes + DBytesW'(pg_bytes[i]);
            end else begin
              live++;
            end
          end
        end
        r.pages_total = tot;
        r.pages_live  = live;
        r.pages_dead  = deadn;
        r.bytes_dead  = dbytes;
        rsp_due.push_back(r);
        scans_stats++;
      end
      ACT_COLLECT: begin
        n_dead = 0;
        for (int i = 0; i < PAGES_N; i++) if (pg_present[i] && pg_dead[i]) n_dead++;
        if (n_dead == 0) begin
          r.status = ST_NONEDEAD;
          rsp_due.push_back(r);
        end else begin
          k = 0;
          for (int i = 0; i < PAGES_N; i++) begin
            if (pg_present[i] && pg_dead[i]) begin
              k++;
              r = '0;
              r.status     = ST_OK;
              r.is_dead    = 1'b1;
              r.found_page = IdxW'(i);
              r.last       = (k == n_dead);
              rsp_due.push_back(r);
            end
          end
        end
        if (n_dead > longest_run) longest_run = n_dead;
        scans_collect++;
      end
      default: ;  // unknown code: no result, no change
    endcase
  endtask

  // Idle length: mostly short, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Send one request transaction. Valid is either kept high straight into
  // the next item or dropped for a gap; never both in one step.
  task automatic send_request(input logic [2:0] action, input logic [IdxW-1:0] page,
                              input logic [BytesW-1:0] bytes);
    prt_req_t req;
    int       gap;
    req.action     = action;
    req.page_index = page;
    req.page_bytes = bytes;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (in_stall_o);
    apply_page_action(req);
    if (action != ACT_UNUSED) requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, none started while no_idle is set.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_length() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    prt_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rsp_due.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected result: st=%0d cnt=%h dead=%0b pg=%0d last=%0b",
                   out_o.status, out_o.count_value, out_o.is_dead, out_o.found_page,
                   out_o.last);
      end else begin
        want = rsp_due.pop_front();
        results_checked++;
        if (out_o.status !== want.status || out_o.count_value !== want.count_value ||
            out_o.is_dead !== want.is_dead || out_o.found_page !== want.found_page ||
            out_o.pages_total !== want.pages_total ||
            out_o.pages_live !== want.pages_live ||
            out_o.pages_dead !== want.pages_dead ||
            out_o.bytes_dead !== want.bytes_dead || out_o.last !== want.last) begin
          errors++;
          if (errors <= SHOW_MAX) begin
            $display("mismatch exp: st=%0d cnt=%h dead=%0b pg=%0d last=%0b",
                     want.status, want.count_value, want.is_dead, want.found_page,
                     want.last);
            $display("              tot=%0d live=%0d dn=%0d db=%h",
                     want.pages_total, want.pages_live, want.pages_dead,
                     want.bytes_dead);
            $display("         got: st=%0d cnt=%h dead=%0b pg=%0d last=%0b",
                     out_o.status, out_o.count_value, out_o.is_dead, out_o.found_page,
                     out_o.last);
            $display("              tot=%0d live=%0d dn=%0d db=%h",
                     out_o.pages_total, out_o.pages_live, out_o.pages_dead,
                     out_o.bytes_dead);
          end
        end
      end
    end
  end

  // Watchdog: a stats scan is the longest legal silence, plus the longest stall
  // and gap; the limit is many times that.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb_page_refcount_table failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty table: every point action misses, scans report nothing.
  task automatic test_missing_pages();
    send_request(ACT_QUERY,    6'd17, 32'h0);
    send_request(ACT_INCREF,   6'd63, 32'h0);
    send_request(ACT_DECREF,   6'd0,  32'h0);
    send_request(ACT_MARKDEAD, 6'd5,  32'h0);
    send_request(ACT_STATS,    6'd0,  32'h0);
    send_request(ACT_COLLECT,  6'd0,  32'h0);
  endtask

  // Init at both ends of the index and size ranges, then re-init in place.
  task automatic test_init_and_query();
    send_request(ACT_INIT,  6'd0,  32'hFFFF_FFFF);
    send_request(ACT_INIT,  6'd63, 32'h0);
    send_request(ACT_QUERY, 6'd0,  32'h0);
    send_request(ACT_QUERY, 6'd63, 32'h0);
    send_request(ACT_INIT,  6'd63, 32'h8000_0001);
  endtask

  // Counting up and down, death on reaching zero, decref refused at zero,
  // incref on a dead page keeps it dead. Run without idling on either side.
  // Saturation at the count maximum needs 2^32 - 2 increments from init and is left to
  // the predictor; it cannot be reached through the port in a sane run.
  task automatic test_count_updates();
    no_idle = 1'b1;
    send_request(ACT_INCREF,   6'd0,  32'h0);
    send_request(ACT_INCREF,   6'd0,  32'h0);
    repeat (3) send_request(ACT_DECREF, 6'd0, 32'h0);
    send_request(ACT_DECREF,   6'd0,  32'h0);
    send_request(ACT_INCREF,   6'd0,  32'h0);
    send_request(ACT_MARKDEAD, 6'd63, 32'h0);
    no_idle = 1'b0;
  endtask

  // Mark dead on an already dead page, scans over a mixed table, unused code.
  task automatic test_dead_marking();
    send_request(ACT_DECREF,   6'd0,  32'h0);
    send_request(ACT_MARKDEAD, 6'd0,  32'h0);
    send_request(ACT_INIT,     6'd42, 32'h5555_AAAA);
    send_request(ACT_DECREF,   6'd42, 32'h0);
    send_request(ACT_UNUSED,   6'd21, 32'hDEAD_BEEF);
    send_request(ACT_STATS,    6'd0,  32'h0);
    send_request(ACT_COLLECT,  6'd0,  32'h0);
  endtask

  // Random traffic focused on a few pages so counts often reach zero, with a
  // share spread over the whole table. The middle stretch runs without idling.
  task automatic test_random_traffic();
    int               start;
    int               r;
    logic [2:0]       act;
    logic [IdxW-1:0]  page;
    logic [BytesW-1:0] bytes;
    start = requests_sent;
    while (requests_sent - start < RAND_ITEMS) begin
      no_idle = (requests_sent - start >= 8 && requests_sent - start < 14);
      r = $urandom_range(0, 99);
      if (r < 15)      act = ACT_INIT;
      else if (r < 33) act = ACT_INCREF;
      else if (r < 58) act = ACT_DECREF;
      else if (r < 68) act = ACT_QUERY;
      else if (r < 80) act = ACT_MARKDEAD;
      else if (r < 88) act = ACT_STATS;
      else if (r < 96) act = ACT_COLLECT;
      else             act = ACT_UNUSED;
      page = ($urandom_range(0, 3) == 0) ? IdxW'($urandom_range(0, PAGES_N - 1))
                                         : IdxW'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       bytes = '0;
        1:       bytes = '1;
        default: bytes = $urandom();
      endcase
      send_request(act, page, bytes);
    end
    no_idle = 1'b0;
  endtask

  // Every page present at the largest size, then all dead: the largest
  // byte sum and the longest collect run.
  task automatic test_full_table();
    for (int p = 0; p < PAGES_N; p++) send_request(ACT_INIT, IdxW'(p), '1);
    send_request(ACT_STATS, 6'd0, 32'h0);
    for (int p = 0; p < PAGES_N; p++) send_request(ACT_DECREF, IdxW'(p), 32'h0);
    send_request(ACT_STATS,   6'd0, 32'h0);
    send_request(ACT_COLLECT, 6'd0, 32'h0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_missing_pages();
    test_init_and_query();
    test_count_updates();
    test_dead_marking();
    test_random_traffic();
    test_full_table();

    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (2 * PAGES_N + 8) @(posedge clk_i);

    $display("%0d requests sent, %0d stats and %0d collect scans (longest run %0d pages)",
             requests_sent, scans_stats, scans_collect, longest_run);
    $display("%0d results checked, %0d errors", results_checked, errors);
    if (errors == 0 && rsp_due.size() == 0) begin
      $display("tb_page_refcount_table passed");
    end else begin
      $display("tb_page_refcount_table failed");
    end
    $finish;
  end

endmodule
